// ===== hdl/date_string_validator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Date string validator assertion macros
// Concurrent assertion helpers on i_clk with i_rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef DATE_STRING_VALIDATOR_UNIT_DEFINES_SVH
`define DATE_STRING_VALIDATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define DSVU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define DSVU_ASSERT_NEVER(lbl, expr, msg) \
    `DSVU_ASSERT(lbl, !(expr), msg)
`else
`define DSVU_ASSERT(lbl, prop, msg)
`define DSVU_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== hdl/dsv_pkg.sv =====
// ----------------------------------------------------------------------------
// Date string validator package
// Shared types, codes, character range tables and the month length table.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [3:0] {
        SCAN_D1     = 4'd0,
        SCAN_D2     = 4'd1,
        SCAN_SL1    = 4'd2,
        SCAN_M1     = 4'd3,
        SCAN_M2     = 4'd4,
        SCAN_SL2    = 4'd5,
        SCAN_Y1     = 4'd6,
        SCAN_Y2     = 4'd7,
        SCAN_Y3     = 4'd8,
        SCAN_Y4     = 4'd9,
        SCAN_ACCEPT = 4'd10,
        SCAN_DEAD   = 4'd11
    } t_scan;

    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_FORMAT   = 2'd1,
        ST_CALENDAR = 2'd2
    } t_status;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [4:0] MONTH_FEB  = 5'd2;
    localparam logic [4:0] MONTH_LAST = 5'd12;
    localparam logic [4:0] LEAP_FEB   = 5'd29;

    // year / 100 == (year * RECIP_100) >> RECIP_SHIFT for all 14-bit years
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic       fmt_ok;
        logic [5:0] day;
        logic [4:0] month;
        logic [13:0] year;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] char_lo(input t_scan pos);
        unique case (pos)
            SCAN_SL1, SCAN_SL2: char_lo = CHAR_SLASH;
            SCAN_Y1:            char_lo = CHAR_ONE;
            default:            char_lo = CHAR_ZERO;
        endcase
    endfunction

    function automatic logic [7:0] char_hi(input t_scan pos);
        unique case (pos)
            SCAN_D1:            char_hi = CHAR_THREE;
            SCAN_M1:            char_hi = CHAR_ONE;
            SCAN_SL1, SCAN_SL2: char_hi = CHAR_SLASH;
            default:            char_hi = CHAR_NINE;
        endcase
    endfunction

    function automatic logic [4:0] month_len(input logic [4:0] month);
        unique case (month)
            5'd2:                    month_len = 5'd28;
            5'd4, 5'd6, 5'd9, 5'd11: month_len = 5'd30;
            default:                 month_len = 5'd31;
        endcase
    endfunction

endpackage

// ===== hdl/dsv_front.sv =====
// ----------------------------------------------------------------------------
// Date string validator front end
// Runs the format recognizer, accumulates day, month and year, and pushes
// one record per end marker into the queue.
// ----------------------------------------------------------------------------
module dsv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_char_code,
    input  logic           i_end_marker,
    input  dsv_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output dsv_pkg::t_rec  o_push_rec
);
    import dsv_pkg::*;

    t_scan       r_pos, n_pos;
    logic [5:0]  r_day, n_day;
    logic [4:0]  r_month, n_month;
    logic [13:0] r_year, n_year;
    logic        accept;
    logic        in_range;
    logic [3:0]  digit;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;
    assign digit   = i_char_code[3:0];
    assign in_range = (i_char_code >= char_lo(r_pos)) && (i_char_code <= char_hi(r_pos));

    assign o_push              = accept && i_end_marker;
    assign o_push_rec.fmt_ok   = (r_pos == SCAN_ACCEPT);
    assign o_push_rec.day      = r_day;
    assign o_push_rec.month    = r_month;
    assign o_push_rec.year     = r_year;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= SCAN_D1;
            r_day   <= '0;
            r_month <= '0;
            r_year  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_day   <= n_day;
            r_month <= n_month;
            r_year  <= n_year;
        end
    end

    always_comb begin
        n_pos   = r_pos;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        if (accept) begin
            if (i_end_marker) begin
                n_pos   = SCAN_D1;
                n_day   = '0;
                n_month = '0;
                n_year  = '0;
            end else begin
                unique case (r_pos)
                    SCAN_D1, SCAN_D2, SCAN_SL1, SCAN_M1, SCAN_M2,
                    SCAN_SL2, SCAN_Y1, SCAN_Y2, SCAN_Y3, SCAN_Y4: begin
                        if (in_range) begin
                            n_pos = t_scan'(r_pos + 4'd1);
                            priority case (r_pos)
                                SCAN_D1, SCAN_D2:
                                    n_day = {r_day[2:0], 3'b000} + {r_day[4:0], 1'b0}
                                          + {2'b00, digit};
                                SCAN_M1, SCAN_M2:
                                    n_month = {r_month[1:0], 3'b000}
                                            + {r_month[3:0], 1'b0} + {1'b0, digit};
                                SCAN_Y1, SCAN_Y2, SCAN_Y3, SCAN_Y4:
                                    n_year = {r_year[10:0], 3'b000}
                                           + {r_year[12:0], 1'b0} + {10'd0, digit};
                                default: ;
                            endcase
                        end else begin
                            n_pos = SCAN_DEAD;
                        end
                    end
                    default: n_pos = SCAN_DEAD;
                endcase
            end
        end
    end

endmodule

// ===== hdl/dsv_queue.sv =====
// ----------------------------------------------------------------------------
// Date string validator record queue
// Small first-word-fall-through queue between front and back ends.
// ----------------------------------------------------------------------------
module dsv_queue #(
    parameter int Depth = dsv_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  dsv_pkg::t_rec    i_push_rec,
    input  logic             i_pop,
    output dsv_pkg::t_rec    o_head,
    output dsv_pkg::t_q_stat o_stat
);
    import dsv_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    t_rec            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            do_push;
    logic            do_pop;

    assign o_stat.full  = (r_count == CntFull);
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CntW'(1);
        end
    end

endmodule

// ===== hdl/dsv_back.sv =====
// ----------------------------------------------------------------------------
// Date string validator back end
// Two-stage calendar check: century quotient, then leap rule, month length
// and status into the output register.
// ----------------------------------------------------------------------------
module dsv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dsv_pkg::t_rec    i_head,
    input  dsv_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_date_ok,
    output logic [1:0]       o_status
);
    import dsv_pkg::*;

    logic        r_a_valid;
    t_rec        r_a_rec;
    logic [7:0]  r_a_quot;
    logic        r_o_valid;
    logic        r_o_ok;
    t_status     r_o_status;

    logic        out_free;
    logic        a_free;
    logic [26:0] prod;
    logic [13:0] quot_x100;
    logic [13:0] rem100;
    logic        century;
    logic        leap;
    logic [4:0]  lim;
    t_status     n_status;

    assign out_free = !r_o_valid || i_ready;
    assign a_free   = !r_a_valid || out_free;
    assign o_pop    = a_free && !i_q_stat.empty;

    assign prod = {13'd0, i_head.year} * {14'd0, RECIP_100};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= !i_q_stat.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_rec  <= i_head;
            r_a_quot <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
        end
    end

    assign quot_x100 = {r_a_quot, 6'd0} + {1'b0, r_a_quot, 5'd0} + {4'd0, r_a_quot, 2'd0};
    assign rem100    = r_a_rec.year - quot_x100;
    assign century   = (rem100 == '0);
    assign leap      = century ? (r_a_quot[1:0] == 2'b00)
                               : (r_a_rec.year[1:0] == 2'b00);

    always_comb begin
        lim = month_len(r_a_rec.month);
        if (r_a_rec.month == MONTH_FEB && leap) begin
            lim = LEAP_FEB;
        end
        priority if (!r_a_rec.fmt_ok) begin
            n_status = ST_FORMAT;
        end else if (r_a_rec.month == '0 || r_a_rec.month > MONTH_LAST) begin
            n_status = ST_CALENDAR;
        end else if (r_a_rec.day == '0 || r_a_rec.day > {1'b0, lim}) begin
            n_status = ST_CALENDAR;
        end else begin
            n_status = ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_a_valid) begin
            r_o_ok     <= (n_status == ST_VALID);
            r_o_status <= n_status;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_date_ok = r_o_ok;
    assign o_status  = r_o_status;

endmodule

// ===== hdl/date_string_validator_unit.sv =====
// ----------------------------------------------------------------------------
// Date string validator
// Checks DD/MM/YYYY strings one character per beat and reports validity.
// ----------------------------------------------------------------------------
// Input channel: one beat per character (i_char_code) or one end-marker beat
// (i_end_marker high, character ignored) that closes the string. Output
// channel: one beat per end marker with o_date_ok and o_status (valid,
// format error, calendar error); characters produce no output beat.
// Throughput: one input beat per cycle while o_ready is high. The front end
// steps the recognizer and digit accumulators once per accepted character.
// A result passes the queue write, the quotient stage and the status
// register before it is presented; the queue is registered and is not
// bypassed even when the back end is idle.
// The back end takes one record per cycle when not stalled; its first stage
// forms year / 100 by reciprocal multiply, the second the leap rule and limits.
// When the receiver stalls, the output register holds, the back end stops,
// and the queue absorbs end markers; o_ready drops only when it is full.
// Reset clears the recognizer to its start state, the accumulators, the
// queue and all valid flags; no output beat is pending after reset.
// ----------------------------------------------------------------------------
`include "date_string_validator_unit_defines.svh"

module date_string_validator_unit #(
    parameter int QueueDepth = dsv_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_end_marker,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_date_ok,
    output logic [1:0] o_status
);
    import dsv_pkg::*;

    t_q_stat q_stat;
    t_rec    push_rec;
    t_rec    head;
    logic    push;
    logic    pop;

    dsv_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_code  (i_char_code),
        .i_end_marker (i_end_marker),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_push_rec   (push_rec)
    );

    dsv_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_head     (head),
        .o_stat     (q_stat)
    );

    dsv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_date_ok (o_date_ok),
        .o_status  (o_status)
    );

    `DSVU_ASSERT_NEVER(a_no_overflow, push && q_stat.full, "queue push while full")
    `DSVU_ASSERT(a_marker_queued, push |=> !q_stat.empty, "end marker not queued")
    `DSVU_ASSERT(a_ok_matches, o_valid |-> (o_date_ok == (o_status == ST_VALID)), "ok flag mismatch")
    `DSVU_ASSERT_NEVER(a_status_code, o_valid && (o_status > ST_CALENDAR), "undefined status code")

endmodule
